// ===== hw/rtl/tlfs_pkg.sv =====
// Shared types and constants of the three-level feedback scheduler.
package tlfs_pkg;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_SLICE0 = 1'b0;
    localparam logic REG_SLICE1 = 1'b1;

    localparam logic [1:0] LVL0 = 2'd0;
    localparam logic [1:0] LVL1 = 2'd1;
    localparam logic [1:0] LVL2 = 2'd2;

    localparam int          NUM_LEVELS    = 3;
    localparam int          SLICE_BITS    = 8;
    localparam int          TICK_BITS     = 16;
    localparam logic [7:0]  SLICE0_RESET  = 8'd2;
    localparam logic [7:0]  SLICE1_RESET  = 8'd4;
    localparam logic [7:0]  SLICE_MAX     = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } tlfs_cmd_t;

endpackage

// ===== hw/rtl/tlfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tlfs_ctrl.sv =====
// Controller state machine: takes a request in the idle state, then runs the execute state.
module tlfs_ctrl
    import tlfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output tlfs_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.exec;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

// ===== hw/rtl/tlfs_datapath.sv =====
// Datapath: level FIFOs in RAM, pointers, running task, slice registers, results.
module tlfs_datapath
    import tlfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8,
    parameter int BURST_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlfs_cmd_t             cmd,
    input  logic                  command,
    input  logic [ID_BITS-1:0]    proc_id,
    input  logic [BURST_BITS-1:0] burst_length,
    input  logic                  wr_en,
    input  logic                  wr_index,
    input  logic [SLICE_BITS-1:0] wr_data,
    output logic                  run_valid,
    output logic [ID_BITS-1:0]    run_id,
    output logic [1:0]            run_level,
    output logic                  finished,
    output logic                  demoted,
    output logic [TICK_BITS-1:0]  tick_time,
    output logic                  arrival_refused
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + BURST_BITS;

    // Latched request.
    logic                  cmd_q;
    logic [ID_BITS-1:0]    id_q;
    logic [BURST_BITS-1:0] burst_q;

    logic [SLICE_BITS-1:0] slice0_reg;
    logic [SLICE_BITS-1:0] slice1_reg;

    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] tail_reg [NUM_LEVELS];
    logic [CW-1:0] cnt_reg  [NUM_LEVELS];
    logic [PW-1:0] head_next [NUM_LEVELS];
    logic [PW-1:0] tail_next [NUM_LEVELS];
    logic [CW-1:0] cnt_next  [NUM_LEVELS];

    logic [NUM_LEVELS-1:0] push;
    logic [NUM_LEVELS-1:0] pop;
    logic [EW-1:0]         ram_wdata [NUM_LEVELS];
    logic [EW-1:0]         ram_rdata [NUM_LEVELS];

    logic                  run_on_reg, run_on_next;
    logic [ID_BITS-1:0]    run_id_reg, run_id_next;
    logic [BURST_BITS-1:0] run_rem_reg, run_rem_next;
    logic [1:0]            run_lvl_reg, run_lvl_next;
    logic [SLICE_BITS-1:0] slice_cnt_reg, slice_cnt_next;
    logic [CW-1:0]         live_reg, live_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;

    // Task seen on this tick, either the running one or a fresh head.
    logic                  have;
    logic [ID_BITS-1:0]    cur_id;
    logic [BURST_BITS-1:0] cur_rem;
    logic [1:0]            cur_lvl;
    logic [SLICE_BITS-1:0] cur_slice;
    logic [SLICE_BITS:0]   used;
    logic [BURST_BITS-1:0] rem_dec;

    logic                  res_valid_next;
    logic                  res_fin_next;
    logic                  res_dem_next;
    logic                  res_ref_next;

    logic                  run_valid_reg;
    logic [ID_BITS-1:0]    run_id_out_reg;
    logic [1:0]            run_level_reg;
    logic                  finished_reg;
    logic                  demoted_reg;
    logic [TICK_BITS-1:0]  tick_time_reg;
    logic                  refused_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_LEVELS; g++)
        begin : g_level
            tlfs_ram #(
                .WIDTH (EW),
                .DEPTH (QUEUE_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (push[g]),
                .waddr (tail_reg[g]),
                .wdata (ram_wdata[g]),
                .raddr (head_reg[g]),
                .rdata (ram_rdata[g])
            );

            always_comb
            begin
                head_next[g] = head_reg[g];
                tail_next[g] = tail_reg[g];
                cnt_next[g]  = cnt_reg[g];
                if (pop[g])
                begin
                    head_next[g] = (head_reg[g] == PW'(QUEUE_DEPTH - 1)) ?
                                   '0 : head_reg[g] + 1'b1;
                end
                if (push[g])
                begin
                    tail_next[g] = (tail_reg[g] == PW'(QUEUE_DEPTH - 1)) ?
                                   '0 : tail_reg[g] + 1'b1;
                end
                if (push[g] && !pop[g])
                begin
                    cnt_next[g] = cnt_reg[g] + 1'b1;
                end
                else if (pop[g] && !push[g])
                begin
                    cnt_next[g] = cnt_reg[g] - 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    head_reg[g] <= '0;
                    tail_reg[g] <= '0;
                    cnt_reg[g]  <= '0;
                end
                else
                begin
                    head_reg[g] <= head_next[g];
                    tail_reg[g] <= tail_next[g];
                    cnt_reg[g]  <= cnt_next[g];
                end
            end
        end
    endgenerate

    // Pick the task for this tick. RAM read data holds the head of each level,
    // since the head address was stable during the cycle that took the request.
    always_comb
    begin
        have      = 1'b0;
        cur_id    = run_id_reg;
        cur_rem   = run_rem_reg;
        cur_lvl   = run_lvl_reg;
        cur_slice = slice_cnt_reg;
        pop       = '0;
        if (run_on_reg)
        begin
            have = 1'b1;
        end
        else if (cnt_reg[0] != '0)
        begin
            have = 1'b1;
            {cur_id, cur_rem} = ram_rdata[0];
            cur_lvl   = LVL0;
            cur_slice = '0;
            pop[0]    = 1'b1;
        end
        else if (cnt_reg[1] != '0)
        begin
            have = 1'b1;
            {cur_id, cur_rem} = ram_rdata[1];
            cur_lvl   = LVL1;
            cur_slice = '0;
            pop[1]    = 1'b1;
        end
        else if (cnt_reg[2] != '0)
        begin
            have = 1'b1;
            {cur_id, cur_rem} = ram_rdata[2];
            cur_lvl   = LVL2;
            cur_slice = '0;
            pop[2]    = 1'b1;
        end
        if (!(cmd.exec && cmd_q == CMD_TICK))
        begin
            pop = '0;
        end
    end

    assign used    = {1'b0, cur_slice} + 1'b1;
    assign rem_dec = cur_rem - 1'b1;

    assign ram_wdata[0] = {id_q, burst_q};
    assign ram_wdata[1] = {cur_id, rem_dec};
    assign ram_wdata[2] = {cur_id, rem_dec};

    always_comb
    begin
        run_on_next    = run_on_reg;
        run_id_next    = run_id_reg;
        run_rem_next   = run_rem_reg;
        run_lvl_next   = run_lvl_reg;
        slice_cnt_next = slice_cnt_reg;
        live_next      = live_reg;
        tick_next      = tick_reg;
        push           = '0;
        res_valid_next = 1'b0;
        res_fin_next   = 1'b0;
        res_dem_next   = 1'b0;
        res_ref_next   = 1'b0;
        if (cmd.exec)
        begin
            if (cmd_q == CMD_ARRIVE)
            begin
                if (live_reg >= CW'(QUEUE_DEPTH))
                begin
                    res_ref_next = 1'b1;
                end
                else
                begin
                    push[0]   = 1'b1;
                    live_next = live_reg + 1'b1;
                end
            end
            else
            begin
                tick_next = tick_reg + 1'b1;
                if (have)
                begin
                    res_valid_next = 1'b1;
                    run_id_next    = cur_id;
                    run_lvl_next   = cur_lvl;
                    run_on_next    = 1'b1;
                    if (cur_rem <= BURST_BITS'(1))
                    begin
                        res_fin_next   = 1'b1;
                        run_on_next    = 1'b0;
                        run_rem_next   = '0;
                        slice_cnt_next = '0;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        run_rem_next = rem_dec;
                        if (cur_lvl == LVL0 && used >= {1'b0, slice0_reg})
                        begin
                            push[1]        = 1'b1;
                            res_dem_next   = 1'b1;
                            run_on_next    = 1'b0;
                            slice_cnt_next = '0;
                        end
                        else if (cur_lvl == LVL1 && used >= {1'b0, slice1_reg})
                        begin
                            push[2]        = 1'b1;
                            res_dem_next   = 1'b1;
                            run_on_next    = 1'b0;
                            slice_cnt_next = '0;
                        end
                        else
                        begin
                            slice_cnt_next = used[SLICE_BITS] ?
                                             SLICE_MAX : used[SLICE_BITS-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_on_reg    <= 1'b0;
            run_id_reg    <= '0;
            run_rem_reg   <= '0;
            run_lvl_reg   <= LVL0;
            slice_cnt_reg <= '0;
            live_reg      <= '0;
            tick_reg      <= '0;
            slice0_reg    <= SLICE0_RESET;
            slice1_reg    <= SLICE1_RESET;
        end
        else
        begin
            run_on_reg    <= run_on_next;
            run_id_reg    <= run_id_next;
            run_rem_reg   <= run_rem_next;
            run_lvl_reg   <= run_lvl_next;
            slice_cnt_reg <= slice_cnt_next;
            live_reg      <= live_next;
            tick_reg      <= tick_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_SLICE0: slice0_reg <= wr_data;
                    REG_SLICE1: slice1_reg <= wr_data;
                    default:    slice0_reg <= slice0_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_q   <= command;
            id_q    <= proc_id;
            burst_q <= burst_length;
        end
        if (cmd.exec)
        begin
            run_valid_reg  <= res_valid_next;
            run_id_out_reg <= res_valid_next ? cur_id : '0;
            run_level_reg  <= res_valid_next ? cur_lvl : LVL0;
            finished_reg   <= res_fin_next;
            demoted_reg    <= res_dem_next;
            tick_time_reg  <= tick_reg;
            refused_reg    <= res_ref_next;
        end
    end

    assign run_valid       = run_valid_reg;
    assign run_id          = run_id_out_reg;
    assign run_level       = run_level_reg;
    assign finished        = finished_reg;
    assign demoted         = demoted_reg;
    assign tick_time       = tick_time_reg;
    assign arrival_refused = refused_reg;

endmodule

// ===== hw/rtl/three_level_feedback_scheduler.sv =====
// Top level of the three-level feedback scheduler.
//
// A request is taken at a rising edge where start is high and busy is low.
// command selects a task arrival (proc_id, burst_length go to the tail of
// level 0) or one time tick (the running task, or the head of the highest
// non-empty level, runs for one tick).
// Every request gives exactly one result: done is high for one cycle and the
// result ports are valid in that cycle. The receiver cannot hold it off.
// The request moves the controller to its execute state; done and the result
// registers are loaded at the end of that state. No request is taken while
// busy is high, and busy is high for the single execute cycle; the level FIFO
// heads sit in registered-read RAMs that are read during the cycle that takes
// the request, and the execute cycle uses that data and writes back pops,
// pushes and the running task. A new request may be taken in the cycle where
// done is high. Slice lengths are written through wr_en, wr_index and wr_data
// while idle; the user is bound to this, as the block does not enforce it.
// Reset clears pointers, counts, the running task and the tick counter, and
// loads the slice registers with 2 and 4; FIFO RAM contents are not cleared.
module three_level_feedback_scheduler
    import tlfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8,
    parameter int BURST_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [ID_BITS-1:0]    proc_id,
    input  logic [BURST_BITS-1:0] burst_length,
    input  logic                  wr_en,
    input  logic                  wr_index,
    input  logic [SLICE_BITS-1:0] wr_data,
    output logic                  done,
    output logic                  run_valid,
    output logic [ID_BITS-1:0]    run_id,
    output logic [1:0]            run_level,
    output logic                  finished,
    output logic                  demoted,
    output logic [TICK_BITS-1:0]  tick_time,
    output logic                  arrival_refused
);

    tlfs_cmd_t cmd;

    tlfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tlfs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .BURST_BITS  (BURST_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (command),
        .proc_id         (proc_id),
        .burst_length    (burst_length),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .run_valid       (run_valid),
        .run_id          (run_id),
        .run_level       (run_level),
        .finished        (finished),
        .demoted         (demoted),
        .tick_time       (tick_time),
        .arrival_refused (arrival_refused)
    );

    // Every result follows an execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    // A request is executed exactly once: no back-to-back execute cycles.
    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute cycle repeated");

    // A task is never both finished and demoted on a tick.
    a_fin_dem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(finished && demoted))
        else $error("task both finished and demoted");

    // Completion and demotion only come with a running task and no refusal.
    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        done && (finished || demoted) |-> run_valid && !arrival_refused)
        else $error("finish or demote flag without a running task");

endmodule
